@@ rtl/rssd_pkg.sv @@
// Shared types and constants for the run-length sprite span decoder.
package rssd_pkg;

	localparam int CoordBits = 16;
	localparam int SpanXW = 16;
	localparam int OpDepth = 4;
	localparam int OpPtrW = $clog2(OpDepth);
	localparam int OpCntW = $clog2(OpDepth + 1);

	localparam logic [7:0] CmdEndImage = 8'h80;
	localparam logic [7:0] CmdShadow = 8'hC0;
	localparam logic [7:0] CmdRepeatN = 8'hC1;

	typedef enum logic [2:0] {
		PH_CMD  = 3'd0,
		PH_LIT  = 3'd1,
		PH_SHA  = 3'd2,
		PH_SHB  = 3'd3,
		PH_C1N  = 3'd4,
		PH_REP  = 3'd5,
		PH_DONE = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_COLOR  = 2'd0,
		KIND_SHADOW = 2'd1,
		KIND_END    = 2'd2
	} span_kind_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_EOL  = 2'd1,
		OP_SKIP = 2'd2,
		OP_SPAN = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] len;
		span_kind_t kind;
		logic [7:0] pal;
		logic       rst;
	} op_t;

	typedef struct packed {
		logic [SpanXW-1:0] x;
		logic [SpanXW-1:0] y;
		logic [7:0]        len;
		span_kind_t        kind;
		logic [7:0]        pal;
	} span_t;

endpackage

@@ rtl/rle_sprite_span_decoder.sv @@
// Top level of the run-length sprite span decoder.
// The decoder takes one coded byte per clock cycle unless its operation queue is full and
// produces at most one pixel span per byte. Operations pass a four-entry queue and spans
// a two-entry buffer, which let either side stall without stopping the other. The front end
// parses bytes combinationally; the back end advances the cursors by one operation per cycle
// unless a span waits for room. A byte marked last restarts the decoder after it.
module rle_sprite_span_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] span_x,
	output logic [15:0] span_y,
	output logic [7:0]  span_length,
	output logic [1:0]  span_kind,
	output logic [7:0]  palette_index
);

	logic take;
	logic front_valid;
	rssd_pkg::op_t front_op;
	logic head_valid, head_take;
	rssd_pkg::op_t head_op;
	rssd_pkg::span_t span;

	assign take = push && !full;

	rssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.op_valid  (front_valid),
		.op        (front_op)
	);

	rssd_op_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take && front_valid),
		.wr_op    (front_op),
		.full     (full),
		.rd_en    (head_take),
		.rd_valid (head_valid),
		.rd_op    (head_op)
	);

	rssd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (head_valid),
		.op       (head_op),
		.op_take  (head_take),
		.empty    (empty),
		.pop      (pop),
		.span     (span)
	);

	assign span_x = span.x;
	assign span_y = span.y;
	assign span_length = span.len;
	assign span_kind = span.kind;
	assign palette_index = span.pal;

endmodule

@@ rtl/rssd_front.sv @@
// Front end: parses coded bytes into cursor and span operations.
module rssd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             op_valid,
	output rssd_pkg::op_t    op
);

	rssd_pkg::phase_t phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic [7:0] pend_dec;

	assign pend_dec = pending_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rssd_pkg::PH_CMD;
			pending_q <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d;
			pending_q <= pending_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		pending_d = pending_q;
		op.code = rssd_pkg::OP_NONE;
		op.len = 8'd0;
		op.kind = rssd_pkg::KIND_COLOR;
		op.pal = 8'd0;
		op.rst = last_byte;
		unique case (phase_q)
			rssd_pkg::PH_CMD: begin
				if (data_byte == 8'd0) begin
					op.code = rssd_pkg::OP_EOL;
				end else if (!data_byte[7]) begin
					pending_d = data_byte;
					phase_d = rssd_pkg::PH_LIT;
				end else if (data_byte == rssd_pkg::CmdEndImage) begin
					op.code = rssd_pkg::OP_SPAN;
					op.kind = rssd_pkg::KIND_END;
					phase_d = rssd_pkg::PH_DONE;
				end else if (!data_byte[6]) begin
					op.code = rssd_pkg::OP_SKIP;
					op.len = {2'b00, data_byte[5:0]};
				end else if (data_byte == rssd_pkg::CmdShadow) begin
					phase_d = rssd_pkg::PH_SHA;
				end else if (data_byte == rssd_pkg::CmdRepeatN) begin
					phase_d = rssd_pkg::PH_C1N;
				end else begin
					pending_d = {2'b00, data_byte[5:0]};
					phase_d = rssd_pkg::PH_REP;
				end
			end
			rssd_pkg::PH_LIT: begin
				op.code = rssd_pkg::OP_SPAN;
				op.len = 8'd1;
				op.pal = data_byte;
				pending_d = pend_dec;
				if (pend_dec == 8'd0) phase_d = rssd_pkg::PH_CMD;
			end
			rssd_pkg::PH_SHA: begin
				if (data_byte[1:0] != 2'b00) begin
					op.code = rssd_pkg::OP_SPAN;
					op.len = {6'd0, data_byte[1:0]};
					op.kind = rssd_pkg::KIND_SHADOW;
					phase_d = rssd_pkg::PH_CMD;
				end else begin
					phase_d = rssd_pkg::PH_SHB;
				end
			end
			rssd_pkg::PH_SHB: begin
				if (data_byte != 8'd0) begin
					op.code = rssd_pkg::OP_SPAN;
					op.len = data_byte;
					op.kind = rssd_pkg::KIND_SHADOW;
				end
				phase_d = rssd_pkg::PH_CMD;
			end
			rssd_pkg::PH_C1N: begin
				pending_d = data_byte;
				phase_d = rssd_pkg::PH_REP;
			end
			rssd_pkg::PH_REP: begin
				if (pending_q != 8'd0) begin
					op.code = rssd_pkg::OP_SPAN;
					op.len = pending_q;
					op.pal = data_byte;
				end
				pending_d = 8'd0;
				phase_d = rssd_pkg::PH_CMD;
			end
			rssd_pkg::PH_DONE: begin
			end
			default: begin
				phase_d = rssd_pkg::PH_CMD;
			end
		endcase
		if (last_byte) begin
			phase_d = rssd_pkg::PH_CMD;
			pending_d = 8'd0;
		end
	end

	assign op_valid = (op.code != rssd_pkg::OP_NONE) || last_byte;

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> phase_q == rssd_pkg::PH_CMD && pending_q == 8'd0)
		else $error("decoder did not restart after the last byte");

endmodule

@@ rtl/rssd_op_queue.sv @@
// Short queue of decoded operations between the front and back ends.
module rssd_op_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rssd_pkg::op_t wr_op,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output rssd_pkg::op_t rd_op
);

	rssd_pkg::op_t mem_q [rssd_pkg::OpDepth];
	logic [rssd_pkg::OpPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [rssd_pkg::OpCntW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = cnt_q == rssd_pkg::OpCntW'(rssd_pkg::OpDepth);
	assign rd_valid = cnt_q != '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == rssd_pkg::OpPtrW'(rssd_pkg::OpDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == rssd_pkg::OpPtrW'(rssd_pkg::OpDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rssd_pkg::OpCntW'(rssd_pkg::OpDepth))
		else $error("operation queue count beyond its depth");

endmodule

@@ rtl/rssd_back.sv @@
// Back end: applies operations to the cursors and buffers finished spans.
module rssd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  rssd_pkg::op_t op,
	output logic          op_take,
	output logic          empty,
	input  logic          pop,
	output rssd_pkg::span_t span
);

	logic [rssd_pkg::CoordBits-1:0] cur_x_q, cur_y_q;
	rssd_pkg::span_t buf_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_pop, room, emit;

	assign empty = cnt_q == 2'd0;
	assign do_pop = pop && !empty;
	assign room = (cnt_q != 2'd2) || do_pop;
	assign op_take = op_valid && ((op.code != rssd_pkg::OP_SPAN) || room);
	assign emit = op_take && (op.code == rssd_pkg::OP_SPAN);
	assign span = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			buf_q[wr_ptr_q].x <= rssd_pkg::SpanXW'(cur_x_q);
			buf_q[wr_ptr_q].y <= rssd_pkg::SpanXW'(cur_y_q);
			buf_q[wr_ptr_q].len <= op.len;
			buf_q[wr_ptr_q].kind <= op.kind;
			buf_q[wr_ptr_q].pal <= op.pal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (op_take) begin
				if (op.rst) begin
					cur_x_q <= '0;
					cur_y_q <= '0;
				end else begin
					case (op.code)
						rssd_pkg::OP_EOL: begin
							cur_x_q <= '0;
							cur_y_q <= cur_y_q + 1'b1;
						end
						rssd_pkg::OP_SKIP, rssd_pkg::OP_SPAN: begin
							cur_x_q <= cur_x_q + rssd_pkg::CoordBits'(op.len);
						end
						default: begin
						end
					endcase
				end
			end
			if (emit) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (emit && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !emit) cnt_q <= cnt_q - 2'd1;
		end
	end

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("span buffer count beyond two");

	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !do_pop |=> !empty)
		else $error("emitted span not visible at the output");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the run-length sprite span decoder.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [7:0] CmdEndLine   = 8'h00;
	localparam logic [7:0] CmdLitMax    = 8'h7F;
	localparam logic [7:0] CmdSkipMin   = 8'h81;
	localparam logic [7:0] CmdSkipMax   = 8'hBF;
	localparam logic [7:0] CmdRepeatMin = 8'hC2;
	localparam logic [7:0] CmdRepeatMax = 8'hFF;
	localparam int TotalItems = 1150;
	localparam int IdleLimit = 1000;
	localparam int DrainCycles = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty;
	logic        pop;
	logic [15:0] span_x;
	logic [15:0] span_y;
	logic [7:0]  span_length;
	logic [1:0]  span_kind;
	logic [7:0]  palette_index;

	rssd_pkg::phase_t               dec_phase = rssd_pkg::PH_CMD;
	logic [7:0]                     run_count = '0;
	logic [rssd_pkg::CoordBits-1:0] cur_x = '0;
	logic [rssd_pkg::CoordBits-1:0] cur_y = '0;
	rssd_pkg::span_t                pending_spans[$];

	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	int fail_count = 0;
	int items_sent = 0;
	int bytes_decoded = 0;
	int spans_checked = 0;
	int sprites_sent = 0;
	int idle_cycles = 0;

	rle_sprite_span_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.span_x(span_x),
		.span_y(span_y),
		.span_length(span_length),
		.span_kind(span_kind),
		.palette_index(palette_index)
	);

	always #10 clk = ~clk;

	function automatic int draw_gap(bit idle_on);
		return idle_on ? $urandom_range(0, 13) : 0;
	endfunction

	task automatic emit_span(input logic [7:0] len, input rssd_pkg::span_kind_t kind,
		input logic [7:0] pal);
		rssd_pkg::span_t sp;
		sp.x = cur_x;
		sp.y = cur_y;
		sp.len = len;
		sp.kind = kind;
		sp.pal = pal;
		pending_spans.push_back(sp);
		cur_x = cur_x + len;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		case (dec_phase)
			rssd_pkg::PH_CMD: begin
				if (b == CmdEndLine) begin
					cur_y = cur_y + 1'b1;
					cur_x = '0;
				end else if (b < rssd_pkg::CmdEndImage) begin
					run_count = b;
					dec_phase = rssd_pkg::PH_LIT;
				end else if (b == rssd_pkg::CmdEndImage) begin
					emit_span(8'd0, rssd_pkg::KIND_END, 8'd0);
					dec_phase = rssd_pkg::PH_DONE;
				end else if (b < rssd_pkg::CmdShadow) begin
					cur_x = cur_x + (b - rssd_pkg::CmdEndImage);
				end else if (b == rssd_pkg::CmdShadow) begin
					dec_phase = rssd_pkg::PH_SHA;
				end else if (b == rssd_pkg::CmdRepeatN) begin
					dec_phase = rssd_pkg::PH_C1N;
				end else begin
					run_count = b - rssd_pkg::CmdShadow;
					dec_phase = rssd_pkg::PH_REP;
				end
			end
			rssd_pkg::PH_LIT: begin
				emit_span(8'd1, rssd_pkg::KIND_COLOR, b);
				run_count = run_count - 1'b1;
				if (run_count == 8'd0)
					dec_phase = rssd_pkg::PH_CMD;
			end
			rssd_pkg::PH_SHA: begin
				if (b[1:0] != 2'd0) begin
					emit_span({6'd0, b[1:0]}, rssd_pkg::KIND_SHADOW, 8'd0);
					dec_phase = rssd_pkg::PH_CMD;
				end else begin
					dec_phase = rssd_pkg::PH_SHB;
				end
			end
			rssd_pkg::PH_SHB: begin
				if (b != 8'd0)
					emit_span(b, rssd_pkg::KIND_SHADOW, 8'd0);
				dec_phase = rssd_pkg::PH_CMD;
			end
			rssd_pkg::PH_C1N: begin
				run_count = b;
				dec_phase = rssd_pkg::PH_REP;
			end
			rssd_pkg::PH_REP: begin
				if (run_count != 8'd0)
					emit_span(run_count, rssd_pkg::KIND_COLOR, b);
				run_count = '0;
				dec_phase = rssd_pkg::PH_CMD;
			end
			default: ;
		endcase
		if (last) begin
			dec_phase = rssd_pkg::PH_CMD;
			run_count = '0;
			cur_x = '0;
			cur_y = '0;
		end
	endtask

	// Offers one byte and returns at the edge that accepts it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = draw_gap(in_idle_on);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(negedge clk);
		while (full)
			@(negedge clk);
		items_sent++;
		if (dec_phase != rssd_pkg::PH_DONE)
			bytes_decoded++;
		decode_byte(b, last);
		if (last)
			sprites_sent++;
		@(posedge clk);
	endtask

	task automatic test_every_command();
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7E, 1'b0);
		send_byte(CmdEndLine, 1'b0);
		send_byte(CmdSkipMax, 1'b0);
		send_byte(CmdSkipMin, 1'b0);
		send_byte(rssd_pkg::CmdShadow, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(rssd_pkg::CmdShadow, 1'b0);
		send_byte(8'hFC, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(rssd_pkg::CmdRepeatN, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(CmdRepeatMin, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CmdRepeatMax, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_zero_length_runs();
		send_byte(rssd_pkg::CmdShadow, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(rssd_pkg::CmdRepeatN, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h55, 1'b0);
	endtask

	task automatic test_end_of_image();
		send_byte(rssd_pkg::CmdEndImage, 1'b0);
		send_byte(CmdLitMax, 1'b0);
		send_byte(rssd_pkg::CmdEndImage, 1'b0);
		send_byte(8'h34, 1'b1);
	endtask

	task automatic test_last_byte_abort();
		send_byte(8'h03, 1'b0);
		send_byte(8'h11, 1'b1);
		send_byte(rssd_pkg::CmdRepeatN, 1'b0);
		send_byte(8'h05, 1'b1);
		send_byte(CmdSkipMin, 1'b0);
		send_byte(CmdRepeatMax, 1'b1);
	endtask

	// Walks the column cursor past its top value and back around to zero.
	task automatic test_cursor_wrap();
		in_idle_on = 1'b0;
		repeat (257) begin
			send_byte(rssd_pkg::CmdRepeatN, 1'b0);
			send_byte(8'hFF, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		send_byte(CmdRepeatMin, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(CmdEndLine, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		in_idle_on = 1'b1;
	endtask

	task automatic test_random_sprites();
		logic [7:0] code[$];
		int n;
		int cmds;
		logic [7:0] b;
		while (items_sent < TotalItems) begin
			in_idle_on = $urandom_range(0, 3) != 0;
			out_idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) < 8) begin
				code.delete();
				cmds = $urandom_range(1, 12);
				repeat (cmds) begin
					case ($urandom_range(0, 5))
						0: code.push_back(CmdEndLine);
						1: begin
							n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, CmdLitMax)
								: $urandom_range(1, 6);
							code.push_back(8'(n));
							repeat (n) code.push_back(8'($urandom_range(0, 255)));
						end
						2: code.push_back(8'($urandom_range(CmdSkipMin, CmdSkipMax)));
						3: begin
							b = 8'($urandom_range(0, 255));
							code.push_back(rssd_pkg::CmdShadow);
							code.push_back(b);
							if (b[1:0] == 2'd0)
								code.push_back(($urandom_range(0, 3) == 0) ? 8'd0
									: 8'($urandom_range(0, 255)));
						end
						4: begin
							code.push_back(rssd_pkg::CmdRepeatN);
							code.push_back(($urandom_range(0, 3) == 0) ? 8'd0
								: 8'($urandom_range(0, 255)));
							code.push_back(8'($urandom_range(0, 255)));
						end
						default: begin
							code.push_back(8'($urandom_range(CmdRepeatMin, CmdRepeatMax)));
							code.push_back(8'($urandom_range(0, 255)));
						end
					endcase
				end
				if ($urandom_range(0, 3) != 0) begin
					code.push_back(rssd_pkg::CmdEndImage);
					repeat ($urandom_range(0, 3)) code.push_back(8'($urandom_range(0, 255)));
				end
				if (code.size() > 1 && $urandom_range(0, 4) == 0)
					code = code[0:$urandom_range(0, code.size() - 2)];
				foreach (code[i])
					send_byte(code[i], i == code.size() - 1);
			end else begin
				repeat ($urandom_range(1, 20))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
	endtask

	// Result side: pops with random stalls and checks each beat in order.
	initial begin
		rssd_pkg::span_t want;
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(out_idle_on);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(negedge clk);
			while (empty)
				@(negedge clk);
			if (pending_spans.size() == 0) begin
				$error("span beat with no expected span: x=%0d y=%0d len=%0d kind=%0d pal=%0d",
					span_x, span_y, span_length, span_kind, palette_index);
				fail_count++;
			end else begin
				want = pending_spans.pop_front();
				spans_checked++;
				if (span_x !== want.x) begin
					$error("span_x: expected %0d, got %0d", want.x, span_x);
					fail_count++;
				end
				if (span_y !== want.y) begin
					$error("span_y: expected %0d, got %0d", want.y, span_y);
					fail_count++;
				end
				if (span_length !== want.len) begin
					$error("span_length: expected %0d, got %0d", want.len, span_length);
					fail_count++;
				end
				if (span_kind !== want.kind) begin
					$error("span_kind: expected %0d, got %0d", want.kind, span_kind);
					fail_count++;
				end
				if (palette_index !== want.pal) begin
					$error("palette_index: expected %0d, got %0d", want.pal, palette_index);
					fail_count++;
				end
			end
			@(posedge clk);
		end
	end

	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("Timeout: no beat for %0d cycles, %0d spans still expected",
					idle_cycles, pending_spans.size());
				$display("** rle_sprite_span_decoder: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_every_command();
		test_zero_length_runs();
		test_end_of_image();
		test_last_byte_abort();
		test_cursor_wrap();
		test_random_sprites();
		push <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (pending_spans.size() != 0) begin
			$error("%0d expected spans never arrived", pending_spans.size());
			fail_count++;
		end
		$display("Sent %0d coded bytes over %0d sprites, decoded %0d and checked %0d spans.",
			items_sent, sprites_sent, bytes_decoded, spans_checked);
		$display("Covered every command, zero-length runs, column wrap, end of image and restarts.");
		if (fail_count == 0)
			$display("** rle_sprite_span_decoder: PASSED **");
		else
			$display("** rle_sprite_span_decoder: FAILED **");
		$finish;
	end

endmodule
